>>> src/lzd_pkg.sv
package lzd_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 2;
  localparam int TOTAL_W = 24;
  localparam int CAP_W   = 24;
  localparam int FLAGS   = 8;
  localparam int IDX_W   = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 24'hFFFFFF;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIST  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CAP   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd3;

  // stream parse position
  typedef enum logic [1:0] {
    PH_CTRL,
    PH_ITEM,
    PH_HIGH
  } phase_t;

  // what an incoming byte does in the current parse position
  typedef enum logic [2:0] {
    IA_DROP,
    IA_CTRL,
    IA_LIT,
    IA_LOW,
    IA_MATCH,
    IA_ERR
  } act_t;

  typedef enum logic [1:0] {
    ST_IN,
    ST_PRIME,
    ST_COPY,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic take;
    logic emit_copy;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic in_last;
    logic copy_done;
    logic copy_last;
    logic out_free;
  } sts_t;

endpackage

>>> src/lzd_in_if.sv
interface lzd_in_if;
  import lzd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

>>> src/lzd_out_if.sv
interface lzd_out_if;
  import lzd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data_byte;
  logic [ERR_W-1:0]   error_code;
  logic [TOTAL_W-1:0] total_length;
  logic               last_of_run;

  modport source (
    output valid, output kind, output data_byte, output error_code,
    output total_length, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input error_code,
    input total_length, input last_of_run, output ready
  );
endinterface

>>> src/lzd_cfg_if.sv
interface lzd_cfg_if;
  import lzd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] output_capacity;

  modport source (output valid, output output_capacity, input ready);
  modport sink (input valid, input output_capacity, output ready);
endinterface

>>> src/lzss_decompressor.sv
// channel   dir   payload                                               handshake
// cfg_ch    in    output_capacity                                       valid/ready
// in_ch     in    in_byte, last_byte                                    valid/ready
// out_ch    out   kind, data_byte, error_code, total_length, last_of_run valid/ready
//
// a control, literal or token byte is handled in the cycle it is taken; a match is then
// primed by a history read and copied one byte per cycle while the output register is free
// a literal or match on the final byte is followed by a separate end result
// output is one byte per cycle at best, set by the single history read port
// reset clears stream state and sets capacity to CAP_RESET; history contents are kept unreset
// a stalled output register holds the copy, and in_ch stalls with it
module lzss_decompressor #(
  parameter int WINDOW_BITS = 12,
  parameter int MIN_MATCH   = 3,
  parameter int COUNT_WIDTH = 24
) (
  input logic        clk,
  input logic        rst_n,
  lzd_cfg_if.sink    cfg_ch,
  lzd_in_if.sink     in_ch,
  lzd_out_if.source  out_ch
);
  import lzd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  lzd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzd_datapath #(
    .WINDOW_BITS (WINDOW_BITS),
    .MIN_MATCH   (MIN_MATCH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.output_capacity),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.last_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_data  (out_ch.data_byte),
    .out_err   (out_ch.error_code),
    .out_total (out_ch.total_length),
    .out_last  (out_ch.last_of_run)
  );

endmodule

>>> src/lzd_datapath.sv
module lzd_datapath #(
  parameter int WINDOW_BITS = 12,
  parameter int MIN_MATCH   = 3,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lzd_pkg::CAP_W-1:0]    cfg_data,
  input  logic [lzd_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_last,
  input  lzd_pkg::cmd_t                cmd,
  output lzd_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lzd_pkg::KIND_W-1:0]   out_kind,
  output logic [lzd_pkg::BYTE_W-1:0]   out_data,
  output logic [lzd_pkg::ERR_W-1:0]    out_err,
  output logic [lzd_pkg::TOTAL_W-1:0]  out_total,
  output logic                         out_last
);
  import lzd_pkg::*;

  localparam int WIN_SIZE = 1 << WINDOW_BITS;
  localparam int LEN_W    = $clog2(15 + MIN_MATCH);
  localparam int EXT_W    = ((COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W) + 1;

  function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return ext[TOTAL_W-1:0];
  endfunction

  logic [CAP_W-1:0]       cap_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [FLAGS-1:0]       flag_r;
  logic [IDX_W-1:0]       idx_r;
  phase_t                 phase_r;
  logic [BYTE_W-1:0]      pend_r;
  logic                   failed_r;
  logic [WINDOW_BITS-1:0] dist_r;
  logic [LEN_W-1:0]       len_r;
  logic                   last_r;

  logic [BYTE_W-1:0]      hist_mem [WIN_SIZE];
  logic [BYTE_W-1:0]      rdata_r;
  logic                   fwd_r;
  logic [BYTE_W-1:0]      fwd_data_r;

  logic                   out_valid_r;
  logic [KIND_W-1:0]      out_kind_r;
  logic [BYTE_W-1:0]      out_data_r;
  logic [ERR_W-1:0]       out_err_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic                   out_last_r;

  act_t                   act;
  logic [ERR_W-1:0]       err;
  logic [WINDOW_BITS-1:0] tok_dist;
  logic [EXT_W-1:0]       cnt_ext;
  logic [EXT_W-1:0]       cap_ext;
  logic                   lit_over;
  logic                   match_over;
  logic                   dist_far;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [BYTE_W-1:0]      copy_byte;
  logic                   we;
  logic [WINDOW_BITS-1:0] waddr;
  logic [WINDOW_BITS-1:0] raddr;
  logic [BYTE_W-1:0]      wdata;
  logic                   clr;
  logic                   out_free;
  logic                   ld;
  logic [KIND_W-1:0]      ld_kind;
  logic [BYTE_W-1:0]      ld_data;
  logic [ERR_W-1:0]       ld_err;
  logic [TOTAL_W-1:0]     ld_total;
  logic                   ld_last;

  assign tok_dist   = WINDOW_BITS'({in_byte[7:4], pend_r});
  assign cnt_ext    = EXT_W'(count_r);
  assign cap_ext    = EXT_W'(cap_r);
  assign lit_over   = (cnt_ext + EXT_W'(1)) > cap_ext;
  assign match_over = (cnt_ext + EXT_W'(in_byte[3:0]) + EXT_W'(MIN_MATCH)) > cap_ext;
  assign dist_far   = COUNT_WIDTH'(tok_dist) >= count_r;
  assign count_inc  = count_r + COUNT_WIDTH'(1);

  always_comb begin
    act = IA_DROP;
    err = ERR_NONE;
    if (!failed_r) begin
      unique case (phase_r)
        PH_CTRL: act = IA_CTRL;
        PH_ITEM: begin
          if (flag_r[idx_r]) begin
            if (lit_over) begin
              act = IA_ERR;
              err = ERR_CAP;
            end else begin
              act = IA_LIT;
            end
          end else if (in_last) begin
            act = IA_ERR;
            err = ERR_TRUNC;
          end else begin
            act = IA_LOW;
          end
        end
        PH_HIGH: begin
          if (dist_far) begin
            act = IA_ERR;
            err = ERR_DIST;
          end else if (match_over) begin
            act = IA_ERR;
            err = ERR_CAP;
          end else begin
            act = IA_MATCH;
          end
        end
        default: act = IA_DROP;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;

  assign sts.act       = act;
  assign sts.in_last   = in_last;
  assign sts.copy_done = (len_r == '0);
  assign sts.copy_last = last_r;
  assign sts.out_free  = out_free;

  // history: one write and one registered read per cycle
  assign copy_byte = fwd_r ? fwd_data_r : rdata_r;
  assign we        = (cmd.take && (act == IA_LIT)) || cmd.emit_copy;
  assign wdata     = cmd.emit_copy ? copy_byte : in_byte;
  assign waddr     = count_r[WINDOW_BITS-1:0];
  // source of the byte after the one going out now
  assign raddr     = count_r[WINDOW_BITS-1:0] - dist_r
                     - {{(WINDOW_BITS-1){1'b0}}, ~cmd.emit_copy};

  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[waddr] <= wdata;
    end
    rdata_r    <= hist_mem[raddr];
    fwd_r      <= we && (waddr == raddr);
    fwd_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  assign clr = cmd.emit_end ||
               (cmd.take && in_last &&
                ((act == IA_DROP) || (act == IA_CTRL) || (act == IA_ERR)));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      count_r  <= '0;
      flag_r   <= '0;
      idx_r    <= '0;
      phase_r  <= PH_CTRL;
      pend_r   <= '0;
      failed_r <= 1'b0;
    end else if (cmd.take) begin
      unique case (act)
        IA_CTRL: begin
          flag_r  <= in_byte;
          idx_r   <= '0;
          phase_r <= PH_ITEM;
        end
        IA_LIT: begin
          count_r <= count_inc;
          idx_r   <= idx_r + IDX_W'(1);
          phase_r <= (idx_r == IDX_W'(FLAGS - 1)) ? PH_CTRL : PH_ITEM;
        end
        IA_LOW: begin
          pend_r  <= in_byte;
          phase_r <= PH_HIGH;
        end
        IA_MATCH: begin
          idx_r   <= idx_r + IDX_W'(1);
          phase_r <= (idx_r == IDX_W'(FLAGS - 1)) ? PH_CTRL : PH_ITEM;
        end
        IA_ERR:  failed_r <= 1'b1;
        IA_DROP: ;
        default: ;
      endcase
    end else if (cmd.emit_copy) begin
      count_r <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (act == IA_MATCH)) begin
      dist_r <= tok_dist;
      len_r  <= LEN_W'(in_byte[3:0]) + LEN_W'(MIN_MATCH - 1);
      last_r <= in_last;
    end else if (cmd.emit_copy) begin
      len_r <= len_r - LEN_W'(1);
    end
  end

  always_comb begin
    ld       = 1'b0;
    ld_kind  = KIND_DATA;
    ld_data  = '0;
    ld_err   = ERR_NONE;
    ld_total = to_total(count_r);
    ld_last  = 1'b1;
    if (cmd.take) begin
      unique case (act)
        IA_CTRL: begin
          ld      = in_last;
          ld_kind = KIND_END;
        end
        IA_LIT: begin
          ld       = 1'b1;
          ld_data  = in_byte;
          ld_total = to_total(count_inc);
          ld_last  = !in_last;
        end
        IA_ERR: begin
          ld      = 1'b1;
          ld_kind = KIND_ERR;
          ld_err  = err;
        end
        default: ld = 1'b0;
      endcase
    end else if (cmd.emit_copy) begin
      ld       = 1'b1;
      ld_data  = copy_byte;
      ld_total = to_total(count_inc);
      ld_last  = (len_r == '0) && !last_r;
    end else if (cmd.emit_end) begin
      ld      = 1'b1;
      ld_kind = KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_kind_r  <= ld_kind;
      out_data_r  <= ld_data;
      out_err_r   <= ld_err;
      out_total_r <= ld_total;
      out_last_r  <= ld_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_err   = out_err_r;
  assign out_total = out_total_r;
  assign out_last  = out_last_r;

endmodule

>>> src/lzd_ctrl.sv
module lzd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzd_pkg::sts_t sts,
  output lzd_pkg::cmd_t cmd
);
  import lzd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IN: begin
        in_ready = sts.out_free;
        cmd.take = in_valid && sts.out_free;
        if (cmd.take) begin
          if (sts.act == IA_MATCH) begin
            state_nxt = ST_PRIME;
          end else if ((sts.act == IA_LIT) && sts.in_last) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      // first history read of a match is in flight
      ST_PRIME: state_nxt = ST_COPY;
      ST_COPY: begin
        if (sts.out_free) begin
          cmd.emit_copy = 1'b1;
          if (sts.copy_done) begin
            state_nxt = sts.copy_last ? ST_TAIL : ST_IN;
          end
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = ST_IN;
        end
      end
    endcase
  end

endmodule

>>> src/lzd_checker.sv
module lzd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lzd_pkg::KIND_W-1:0]   out_kind,
  input logic [lzd_pkg::BYTE_W-1:0]   out_data,
  input logic [lzd_pkg::ERR_W-1:0]    out_err,
  input logic [lzd_pkg::TOTAL_W-1:0]  out_total,
  input logic                         out_last
);
  import lzd_pkg::*;

  // end and error results always close the run of their item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != KIND_DATA)) |-> out_last)
    else $error("end or error result without last_of_run");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERR) == (out_err != ERR_NONE)))
    else $error("error code does not match result kind");

  a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != KIND_DATA)) |-> (out_data == '0))
    else $error("nonzero data byte on end or error result");

  // a new item is only taken when its result has room
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_ready)
    else $error("input taken while output register blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_kind, out_data, out_err, out_total, out_last})))
    else $error("stalled result changed");

endmodule

bind lzss_decompressor lzd_checker u_lzd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_data  (out_ch.data_byte),
  .out_err   (out_ch.error_code),
  .out_total (out_ch.total_length),
  .out_last  (out_ch.last_of_run)
);

>>> tb/sv/tb_top.sv
module tb_top;
  import lzd_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RAND_ITEMS   = 480;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic [ERR_W-1:0]   err;
    logic [TOTAL_W-1:0] total;
    logic               lor;
  } res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } item_t;

  typedef enum logic [1:0] {R_CFG, R_ITEM, R_TYPED} row_op_t;

  typedef struct packed {
    row_op_t            op;
    logic [CAP_W-1:0]   val;
    logic               last;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic [ERR_W-1:0]   err;
    logic [TOTAL_W-1:0] total;
  } row_t;

  // typed rows carry their single result, item rows go through the decoder model, cfg rows set capacity
  localparam row_t PLAN [0:30] = '{
    '{R_CFG,   CAP_RESET, 1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h01,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h00,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd1},
    '{R_ITEM,  24'h00,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h0F,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'hFF,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'hF0,    1'b0, KIND_ERR,  8'h00, ERR_DIST,  24'd19},
    '{R_ITEM,  24'h55,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'hAA,    1'b1, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'hFF,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'hFF,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h80,    1'b1, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h00,    1'b1, KIND_END,  8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h00,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h12,    1'b1, KIND_ERR,  8'h00, ERR_TRUNC, 24'd0},
    '{R_ITEM,  24'hFE,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h00,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h00,    1'b0, KIND_ERR,  8'h00, ERR_DIST,  24'd0},
    '{R_ITEM,  24'h00,    1'b1, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_CFG,   24'd0,     1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'hFF,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h11,    1'b0, KIND_ERR,  8'h00, ERR_CAP,   24'd0},
    '{R_ITEM,  24'h00,    1'b1, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_CFG,   24'd4,     1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h01,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h41,    1'b0, KIND_DATA, 8'h41, ERR_NONE,  24'd1},
    '{R_ITEM,  24'h00,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h00,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_ITEM,  24'h01,    1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0},
    '{R_TYPED, 24'h00,    1'b1, KIND_ERR,  8'h00, ERR_CAP,   24'd4},
    '{R_CFG,   CAP_RESET, 1'b0, KIND_DATA, 8'h00, ERR_NONE,  24'd0}
  };

  logic clk;
  logic rst_n;

  lzd_cfg_if cfg_ch ();
  lzd_in_if  in_ch ();
  lzd_out_if out_ch ();

  lzss_decompressor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder model state
  logic [BYTE_W-1:0]  hist_mem [4096];
  logic [TOTAL_W-1:0] out_count;
  logic [BYTE_W-1:0]  ctrl_flags;
  logic [3:0]         flag_pos;
  phase_t             parse_ph;
  logic [BYTE_W-1:0]  low_byte;
  bit                 dropping;
  logic [CAP_W-1:0]   cap_limit;

  res_t decoded_due [$];
  int   mismatch_cnt;
  int   stall_cycles;

  bit quiet;
  bit calm;
  bit hold_req;
  bit hold_taken;
  int hold_left;
  int out_gap;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void stream_reset();
    out_count  = '0;
    ctrl_flags = '0;
    flag_pos   = '0;
    parse_ph   = PH_CTRL;
    low_byte   = '0;
    dropping   = 1'b0;
  endfunction

  function automatic res_t make_res(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                    logic [ERR_W-1:0] err);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.err   = err;
    r.total = out_count;
    r.lor   = 1'b0;
    return r;
  endfunction

  function automatic void put_byte(logic [BYTE_W-1:0] v, ref res_t rs[$]);
    hist_mem[out_count[11:0]] = v;
    out_count = out_count + TOTAL_W'(1);
    rs.push_back(make_res(KIND_DATA, v, ERR_NONE));
  endfunction

  function automatic void advance_flag();
    flag_pos = flag_pos + 4'd1;
    if (flag_pos >= 4'd8) begin
      flag_pos = '0;
      parse_ph = PH_CTRL;
    end else begin
      parse_ph = PH_ITEM;
    end
  endfunction

  // decode one compressed byte into the bytes and status it produces
  function automatic void lz_decode_step(logic [BYTE_W-1:0] b, logic last, ref res_t rs[$]);
    logic [ERR_W-1:0] err;
    logic [12:0]      back_dist;
    logic [4:0]       len;
    logic [11:0]      rd_idx;
    err = ERR_NONE;
    rs.delete();
    if (dropping) begin
      if (last) stream_reset();
      return;
    end
    case (parse_ph)
      PH_CTRL: begin
        ctrl_flags = b;
        flag_pos   = '0;
        parse_ph   = PH_ITEM;
      end
      PH_ITEM: begin
        if (ctrl_flags[flag_pos[2:0]]) begin
          if ({1'b0, out_count} + 25'd1 > {1'b0, cap_limit}) begin
            err = ERR_CAP;
          end else begin
            put_byte(b, rs);
            advance_flag();
          end
        end else if (last) begin
          err = ERR_TRUNC;
        end else begin
          low_byte = b;
          parse_ph = PH_HIGH;
        end
      end
      default: begin
        back_dist = {1'b0, b[7:4], low_byte} + 13'd1;
        len       = {1'b0, b[3:0]} + 5'd3;
        if ({11'd0, back_dist} > out_count) begin
          err = ERR_DIST;
        end else if ({1'b0, out_count} + 25'(len) > {1'b0, cap_limit}) begin
          err = ERR_CAP;
        end else begin
          for (int k = 0; k < int'(len); k++) begin
            rd_idx = out_count[11:0] - back_dist[11:0];
            put_byte(hist_mem[rd_idx], rs);
          end
          advance_flag();
        end
      end
    endcase
    if (err != ERR_NONE) begin
      rs.push_back(make_res(KIND_ERR, 8'h00, err));
      dropping = 1'b1;
      if (last) stream_reset();
    end else if (last) begin
      rs.push_back(make_res(KIND_END, 8'h00, ERR_NONE));
      stream_reset();
    end
    if (rs.size() > 0) rs[rs.size()-1].lor = 1'b1;
  endfunction

  task automatic send_item(logic [BYTE_W-1:0] b, logic last, bit typed, res_t want);
    int   gap;
    res_t rs [$];
    gap = (!quiet && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    lz_decode_step(b, last, rs);
    if (typed) begin
      decoded_due.push_back(want);
    end else begin
      foreach (rs[k]) decoded_due.push_back(rs[k]);
    end
  endtask

  // let every expected result arrive, then give the block time to settle
  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_drain();
    @(negedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.output_capacity <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cap_limit = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed streams, with an occasional distance past the output, some cut short or noise
  function automatic void build_stream(ref item_t sq[$]);
    int          cnt;
    int          groups;
    int          ci;
    int          d;
    int          cut;
    logic [7:0]  c;
    logic [11:0] dm1;
    logic [3:0]  lc;
    sq.delete();
    cnt = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) sq.push_back({8'($urandom), 1'b0});
    end else begin
      groups = $urandom_range(1, 4);
      for (int g = 0; g < groups; g++) begin
        c  = 8'($urandom);
        ci = sq.size();
        sq.push_back({c, 1'b0});
        for (int f = 0; f < 8; f++) begin
          if (cnt == 0 && !c[f] && $urandom_range(0, 19) != 0) c[f] = 1'b1;
          if (c[f]) begin
            sq.push_back({8'($urandom), 1'b0});
            cnt++;
          end else begin
            if (cnt == 0 || $urandom_range(0, 29) == 0)
              d = (cnt < 4096) ? cnt + 1 : 4096;
            else
              d = $urandom_range(1, (cnt < 4096) ? cnt : 4096);
            dm1 = 12'(d - 1);
            lc  = 4'($urandom);
            sq.push_back({dm1[7:0], 1'b0});
            sq.push_back({dm1[11:8], lc, 1'b0});
            cnt += int'(lc) + 3;
          end
        end
        sq[ci].b = c;
      end
    end
    cut = ($urandom_range(0, 1) == 0) ? sq.size() - 1 : $urandom_range(0, sq.size() - 1);
    while (sq.size() > cut + 1) void'(sq.pop_back());
    sq[cut].last = 1'b1;
  endfunction

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 7) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.data_byte, out_ch.error_code, out_ch.total_length,
              out_ch.last_of_run};
      if (decoded_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d data=%02h err=%0d total=%0d last=%0b",
                 $time, got.kind, got.data, got.err, got.total, got.lor);
        mismatch_cnt++;
      end else begin
        want = decoded_due.pop_front();
        if (got !== want) begin
          $display("%0t: expected kind=%0d data=%02h err=%0d total=%0d last=%0b", $time,
                   want.kind, want.data, want.err, want.total, want.lor);
          $display("%0t: actual   kind=%0d data=%02h err=%0d total=%0d last=%0b", $time,
                   got.kind, got.data, got.err, got.total, got.lor);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    item_t sq [$];
    int    rand_items;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.in_byte          = '0;
    in_ch.last_byte        = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.output_capacity = '0;
    out_ch.ready           = 1'b0;
    mismatch_cnt           = 0;
    stall_cycles           = 0;
    quiet                  = 1'b0;
    calm                   = 1'b0;
    hold_req               = 1'b0;
    hold_taken             = 1'b0;
    hold_left              = 0;
    out_gap                = 0;
    rand_items             = 0;
    stream_reset();
    cap_limit = CAP_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].op == R_CFG)
        write_capacity(PLAN[i].val);
      else
        send_item(PLAN[i].val[7:0], PLAN[i].last, PLAN[i].op == R_TYPED,
                  '{PLAN[i].kind, PLAN[i].data, PLAN[i].err, PLAN[i].total, 1'b1});
    end

    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_capacity(CAP_RESET);
          1:       write_capacity('0);
          2:       write_capacity(CAP_W'($urandom_range(1, 40)));
          3:       write_capacity(CAP_W'($urandom_range(40, 600)));
          default: write_capacity(CAP_W'($urandom));
        endcase
      end
      calm = ($urandom_range(0, 3) == 0);
      build_stream(sq);
      foreach (sq[j]) begin
        send_item(sq[j].b, sq[j].last, 1'b0, '0);
        rand_items++;
        if (rand_items == 150) hold_req = 1'b1;
        if (rand_items >= 400) quiet = 1'b1;
      end
    end

    wait_drain();
    if (mismatch_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> lzss_decompressor.f
src/lzd_pkg.sv
src/lzd_in_if.sv
src/lzd_out_if.sv
src/lzd_cfg_if.sv
src/lzd_datapath.sv
src/lzd_ctrl.sv
src/lzss_decompressor.sv
src/lzd_checker.sv
tb/sv/tb_top.sv
